/* rtl/counting_semaphore_fifo_waiters_assert.svh */
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define CSFW_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("semaphore check failed in the same cycle");

// Checks that a condition holds in the cycle after its trigger.
`define CSFW_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("semaphore check failed in the following cycle");

`endif

/* rtl/csfw_pkg.sv */
package csfw_pkg;

   localparam int TASK_BITS      = 4;
   localparam int COUNT_OUT_BITS = 16;

   localparam logic OP_WAIT   = 1'b0;
   localparam logic OP_SIGNAL = 1'b1;

   typedef logic [TASK_BITS-1:0]      task_id_type;
   typedef logic [COUNT_OUT_BITS-1:0] count_out_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

/* rtl/csfw_cell.sv */
module csfw_cell import csfw_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  task_id_type   next_tid,
   input  task_id_type   push_tid,
   output task_id_type   tid
);

   task_id_type tid_ff;
   task_id_type tid_in;

   always_comb begin
      tid_in = tid_ff;
      if (ctrl.shift) begin
         tid_in = next_tid;
      end else if (ctrl.load) begin
         tid_in = push_tid;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff <= tid_in;
   end

   assign tid = tid_ff;

endmodule

/* rtl/counting_semaphore_fifo_waiters.sv */
// Counting semaphore with a first-in first-out queue of blocked tasks.
// A transaction is taken at a rising edge with start high and busy low; busy
// stays low, so a new transaction may be issued in every cycle.
// req_opcode selects wait or signal and req_task_id names the task.
// Each transaction yields one result in the cycle after it is taken, shown for exactly one
// cycle with rsp_strobe high; the receiver cannot stall it.
// A wait on a nonzero count is granted; otherwise the task joins the queue,
// or is dropped with rsp_queue_full when the queue is full.
// A signal raises the count (saturating with rsp_overflow) and releases the
// oldest waiter on rsp_woken_task.
// The queue is a row of cells; a release shifts every cell toward the head,
// and an insert loads the cell at the fill level.
// A write on csr_we loads csr_wdata into the count while no task waits.
// Synchronous reset empties the queue, clears the count and drops any
// pending result.
`include "counting_semaphore_fifo_waiters_assert.svh"

module counting_semaphore_fifo_waiters import csfw_pkg::*; #(
   parameter int QUEUE_DEPTH = 8,
   parameter int COUNT_BITS  = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic          req_opcode,
   input  task_id_type   req_task_id,
   output logic          rsp_strobe,
   output logic          rsp_granted,
   output logic          rsp_blocked,
   output logic          rsp_queue_full,
   output logic          rsp_woken_valid,
   output task_id_type   rsp_woken_task,
   output count_out_type rsp_count_now,
   output logic          rsp_overflow,
   input  logic          csr_we,
   input  count_out_type csr_wdata
);

   localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [OCC_BITS-1:0]   OCC_FULL  = OCC_BITS'(QUEUE_DEPTH);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;

   logic          strobe_ff, strobe_in;
   logic          granted_ff, granted_in;
   logic          blocked_ff, blocked_in;
   logic          full_ff, full_in;
   logic          woken_valid_ff, woken_valid_in;
   task_id_type   woken_tid_ff, woken_tid_in;
   logic          overflow_ff, overflow_in;
   count_out_type count_now_ff, count_now_in;

   logic          accept;
   logic          push;
   logic          pop;
   logic [31:0]   count_wide;
   task_id_type   tid_chain [QUEUE_DEPTH+1];
   cell_ctrl_type cell_ctrl [QUEUE_DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign tid_chain[QUEUE_DEPTH] = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign cell_ctrl[i].shift = pop;
      assign cell_ctrl[i].load  = push && (occ_ff == OCC_BITS'(i));

      csfw_cell u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl[i]),
         .next_tid (tid_chain[i+1]),
         .push_tid (req_task_id),
         .tid      (tid_chain[i])
      );
   end

   always_comb begin
      count_in       = count_ff;
      occ_in         = occ_ff;
      push           = 1'b0;
      pop            = 1'b0;
      strobe_in      = accept;
      granted_in     = 1'b0;
      blocked_in     = 1'b0;
      full_in        = 1'b0;
      woken_valid_in = 1'b0;
      woken_tid_in   = '0;
      overflow_in    = 1'b0;
      if (accept) begin
         if (req_opcode == OP_WAIT) begin
            if (count_ff != '0) begin
               count_in   = count_ff - 1'b1;
               granted_in = 1'b1;
            end else begin
               blocked_in = 1'b1;
               if (occ_ff != OCC_FULL) begin
                  push   = 1'b1;
                  occ_in = occ_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
         end else begin
            if (count_ff == COUNT_MAX) begin
               overflow_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
            if (occ_ff != '0) begin
               pop            = 1'b1;
               occ_in         = occ_ff - 1'b1;
               woken_valid_in = 1'b1;
               woken_tid_in   = tid_chain[0];
            end
         end
      end
      if (csr_we && (occ_ff == '0)) begin
         count_in = COUNT_BITS'(csr_wdata);
      end
      count_wide   = 32'(count_in);
      count_now_in = count_wide[COUNT_OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         occ_ff    <= occ_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      granted_ff     <= granted_in;
      blocked_ff     <= blocked_in;
      full_ff        <= full_in;
      woken_valid_ff <= woken_valid_in;
      woken_tid_ff   <= woken_tid_in;
      overflow_ff    <= overflow_in;
      count_now_ff   <= count_now_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_granted     = granted_ff;
   assign rsp_blocked     = blocked_ff;
   assign rsp_queue_full  = full_ff;
   assign rsp_woken_valid = woken_valid_ff;
   assign rsp_woken_task  = woken_tid_ff;
   assign rsp_count_now   = count_now_ff;
   assign rsp_overflow    = overflow_ff;

   `CSFW_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_FULL)
   `CSFW_ASSERT_NEXT(a_result_follows, clock, reset, accept, rsp_strobe)
   `CSFW_ASSERT_NOW(a_outcome_exclusive, clock, reset, rsp_strobe,
      !(rsp_granted && (rsp_blocked || rsp_woken_valid || rsp_overflow)))
   `CSFW_ASSERT_NEXT(a_push_grows, clock, reset, push, occ_ff == $past(occ_ff) + 1'b1)

endmodule
